### rtl/rsbt_pkg.sv
// Types and constants shared by the ray slab box test modules.
`default_nettype none

package rsbt_pkg;

   localparam int DIST_W      = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [DIST_W-1:0] dist_type;

   localparam dist_type DIST_NEG_INF = {1'b1, {(DIST_W-1){1'b0}}};
   localparam dist_type DIST_POS_INF = {1'b0, {(DIST_W-1){1'b1}}};

   typedef struct packed {
      dist_type t_near;
      dist_type t_far;
      logic     behind;
      logic     last;
   } slab_type;

endpackage

`default_nettype wire

### rtl/ray_slab_box_test.sv
// Top level of the ray slab box test: front pipeline, queue and back unit.
// A last slab passes the front A and B registers and the queue before rsp_valid is registered high.
// Throughput: one slab per cycle while req_stall is low, set by the min/max interval update
// in the back unit; the front end is a two-stage pipeline (A and B registers).
// Reset (synchronous, active high) empties the pipeline and queue and returns the
// interval to minus/plus infinity with no miss pending.
`default_nettype none

module ray_slab_box_test #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rsbt_pkg::dist_type req_ray_offset,
   input  wire rsbt_pkg::dist_type req_inverse_direction,
   input  wire rsbt_pkg::dist_type req_slab_near,
   input  wire rsbt_pkg::dist_type req_slab_far,
   input  wire logic               req_last_slab,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit,
   output rsbt_pkg::dist_type      rsp_entry_distance,
   output rsbt_pkg::dist_type      rsp_exit_distance
);
   import rsbt_pkg::*;

   logic              push_valid;
   slab_type          push_slab;
   slab_type          head_slab;
   logic              nonempty;
   logic              pop;
   logic [QCNT_W-1:0] q_count;

   rsbt_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ray_offset       (req_ray_offset),
      .req_inverse_direction(req_inverse_direction),
      .req_slab_near        (req_slab_near),
      .req_slab_far         (req_slab_far),
      .req_last_slab        (req_last_slab),
      .q_count              (q_count),
      .push_valid           (push_valid),
      .push_slab            (push_slab)
   );

   rsbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_slab (push_slab),
      .pop       (pop),
      .head_slab (head_slab),
      .nonempty  (nonempty),
      .count     (q_count)
   );

   rsbt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_slab         (head_slab),
      .nonempty          (nonempty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_entry_distance(rsp_entry_distance),
      .rsp_exit_distance (rsp_exit_distance)
   );

endmodule

`default_nettype wire

### rtl/rsbt_front.sv
// Front end: slab parameter pipeline (difference, multiply, shift, saturate, swap).
`default_nettype none

module rsbt_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire rsbt_pkg::dist_type        req_ray_offset,
   input  wire rsbt_pkg::dist_type        req_inverse_direction,
   input  wire rsbt_pkg::dist_type        req_slab_near,
   input  wire rsbt_pkg::dist_type        req_slab_far,
   input  wire logic                      req_last_slab,
   input  wire logic [rsbt_pkg::QCNT_W-1:0] q_count,
   output logic                           push_valid,
   output rsbt_pkg::slab_type             push_slab
);
   import rsbt_pkg::*;

   localparam int DIFF_W = DIST_W + 1;
   localparam int PROD_W = DIFF_W + DIST_W;

   logic                     a_valid_ff, a_valid_in;
   logic signed [DIFF_W-1:0] a_near_ff, a_near_in;
   logic signed [DIFF_W-1:0] a_far_ff, a_far_in;
   dist_type                 a_inv_ff;
   logic                     a_last_ff;

   logic                     b_valid_ff, b_valid_in;
   logic signed [PROD_W-1:0] b_near_ff, b_near_in;
   logic signed [PROD_W-1:0] b_far_ff, b_far_in;
   logic                     b_neg_ff;
   logic                     b_last_ff;

   logic [QCNT_W-1:0] inflight;
   logic              accept;
   dist_type          sat_near, sat_far;

   function automatic dist_type scale_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0]  q;
      logic [PROD_W-DIST_W:0]    upper;
      dist_type                  r;
      q     = p >>> FRAC_BITS;
      upper = q[PROD_W-1:DIST_W-1];
      if (&upper || ~|upper) begin
         r = q[DIST_W-1:0];
      end else if (q[PROD_W-1]) begin
         r = DIST_NEG_INF;
      end else begin
         r = DIST_POS_INF;
      end
      return r;
   endfunction

   assign inflight  = q_count + QCNT_W'(a_valid_ff) + QCNT_W'(b_valid_ff);
   assign req_stall = (inflight >= QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign a_valid_in = accept;
   assign a_near_in  = DIFF_W'(req_slab_near) - DIFF_W'(req_ray_offset);
   assign a_far_in   = DIFF_W'(req_slab_far) - DIFF_W'(req_ray_offset);

   assign b_valid_in = a_valid_ff;
   assign b_near_in  = a_near_ff * a_inv_ff;
   assign b_far_in   = a_far_ff * a_inv_ff;

   assign sat_near = scale_sat(b_near_ff);
   assign sat_far  = scale_sat(b_far_ff);

   always_comb begin
      push_slab.last = b_last_ff;
      if (b_neg_ff) begin
         push_slab.t_near = sat_far;
         push_slab.t_far  = sat_near;
      end else begin
         push_slab.t_near = sat_near;
         push_slab.t_far  = sat_far;
      end
      push_slab.behind = push_slab.t_far[DIST_W-1];
   end

   assign push_valid = b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_near_ff <= a_near_in;
         a_far_ff  <= a_far_in;
         a_inv_ff  <= req_inverse_direction;
         a_last_ff <= req_last_slab;
      end
      if (a_valid_ff) begin
         b_near_ff <= b_near_in;
         b_far_ff  <= b_far_in;
         b_neg_ff  <= a_inv_ff[DIST_W-1];
         b_last_ff <= a_last_ff;
      end
   end

endmodule

`default_nettype wire

### rtl/rsbt_queue.sv
// Short queue of slab parameters between the front and back units.
`default_nettype none

module rsbt_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push_valid,
   input  wire rsbt_pkg::slab_type          push_slab,
   input  wire logic                        pop,
   output rsbt_pkg::slab_type               head_slab,
   output logic                             nonempty,
   output logic [rsbt_pkg::QCNT_W-1:0]      count
);
   import rsbt_pkg::*;

   slab_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign nonempty  = (count_ff != '0);
   assign count     = count_ff;
   assign head_slab = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_slab;
      end
   end

endmodule

`default_nettype wire

### rtl/rsbt_back.sv
// Back end: running entry/exit interval, miss tracking and result register.
`default_nettype none

module rsbt_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rsbt_pkg::slab_type head_slab,
   input  wire logic               nonempty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit,
   output rsbt_pkg::dist_type      rsp_entry_distance,
   output rsbt_pkg::dist_type      rsp_exit_distance
);
   import rsbt_pkg::*;

   dist_type entry_ff, entry_in;
   dist_type exit_ff, exit_in;
   logic     missed_ff, missed_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_hit_ff;
   dist_type rsp_entry_ff, rsp_exit_ff;
   logic     out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = nonempty && (!head_slab.last || out_free);

   always_comb begin
      entry_in  = entry_ff;
      exit_in   = exit_ff;
      missed_in = missed_ff;
      if (!missed_ff) begin
         if (head_slab.behind) begin
            missed_in = 1'b1;
         end else begin
            if ($signed(head_slab.t_near) > $signed(entry_ff)) begin
               entry_in = head_slab.t_near;
            end
            if ($signed(head_slab.t_far) < $signed(exit_ff)) begin
               exit_in = head_slab.t_far;
            end
            if ($signed(entry_in) > $signed(exit_in)) begin
               missed_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && head_slab.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff     <= DIST_NEG_INF;
         exit_ff      <= DIST_POS_INF;
         missed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (head_slab.last) begin
               entry_ff  <= DIST_NEG_INF;
               exit_ff   <= DIST_POS_INF;
               missed_ff <= 1'b0;
            end else begin
               entry_ff  <= entry_in;
               exit_ff   <= exit_in;
               missed_ff <= missed_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_slab.last) begin
         rsp_hit_ff   <= !missed_in;
         rsp_entry_ff <= missed_in ? '0 : entry_in;
         rsp_exit_ff  <= missed_in ? '0 : exit_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_entry_distance = rsp_entry_ff;
   assign rsp_exit_distance  = rsp_exit_ff;

endmodule

`default_nettype wire

### rtl/rsbt_checker.sv
// Port-level assertions for the ray slab box test, bound to the top level.
`default_nettype none

module rsbt_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic               rsp_hit,
   input wire logic signed [31:0] rsp_entry_distance,
   input wire logic signed [31:0] rsp_exit_distance
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_entry_distance) && $stable(rsp_exit_distance))
      else $error("stalled result item changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_entry_distance == 0 && rsp_exit_distance == 0)
      else $error("miss item carries nonzero distances");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_entry_distance <= rsp_exit_distance)
      else $error("hit item with entry beyond exit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle right after reset");

endmodule

bind ray_slab_box_test rsbt_checker u_rsbt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_hit           (rsp_hit),
   .rsp_entry_distance(rsp_entry_distance),
   .rsp_exit_distance (rsp_exit_distance)
);

`default_nettype wire
